// ----- rtl/core/stepper_step_pulse_generator_defines.svh -----
// ----------------------------------------------------------------------------
// stepper step pulse generator assertion macros
// shared assertion forms, sampled on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef STEPPER_STEP_PULSE_GENERATOR_DEFINES_SVH
`define STEPPER_STEP_PULSE_GENERATOR_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ssp_pkg.sv -----
// ----------------------------------------------------------------------------
// ssp_pkg
// types, codes and widths shared by the step pulse generator modules
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  localparam int MAX_RPM_DEF      = 600;
  localparam int MAX_DIVISION_DEF = 32;
  localparam int ANGLE_QUARTER    = 90;

  // divider unit operand widths
  localparam int DIVD_W = 32;
  localparam int DVSR_W = 16;

  // stored speed is wide enough for a maximum rpm up to 65535
  localparam int SPD_W  = 16;
  localparam int DIV_W  = 6;
  // quotient of maximum division by division, and of the quarter angle
  localparam int DQ_W   = 7;

  localparam logic REG_SPEED    = 1'b0;
  localparam logic REG_DIVISION = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_STEPS = 2'd1,
    OP_ANGLE = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  localparam logic [1:0] DIR_KEEP = 2'd0;
  localparam logic [1:0] DIR_LOW  = 2'd1;

  typedef enum logic [1:0] {
    DSEL_RPM,
    DSEL_MDIV,
    DSEL_ANGQ,
    DSEL_ANGT
  } div_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RC_RPM,
    ST_RC_DIV,
    ST_RC_MUL,
    ST_EXEC,
    ST_ANG_Q,
    ST_ANG_T,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic     capture_item;
    logic     do_tick;
    logic     do_move;
    logic     move_from_div;
    logic     do_stop;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_q_hi;
    logic     cap_q_lo;
    logic     load_divider;
    logic     clr_pending;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic recalc_pending;
    logic div_done;
    op_t  op;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/ssp_if.sv -----
// ----------------------------------------------------------------------------
// ssp_if
// request and result channel interfaces with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface ssp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  direction;
  logic [31:0] amount;

  modport source (output valid, output operation, output direction, output amount,
                  input ready);
  modport sink   (input valid, input operation, input direction, input amount,
                  output ready);
endinterface

interface ssp_out_if;
  logic        valid;
  logic        ready;
  logic        step_line;
  logic        direction_line;
  logic        enable_line;
  logic        running;
  logic [31:0] steps_done;

  modport source (output valid, output step_line, output direction_line,
                  output enable_line, output running, output steps_done, input ready);
  modport sink   (input valid, input step_line, input direction_line,
                  input enable_line, input running, input steps_done, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ssp_div.sv -----
// ----------------------------------------------------------------------------
// ssp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_div (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire [ssp_pkg::DIVD_W-1:0] dividend,
  input  wire [ssp_pkg::DVSR_W-1:0] divisor,
  output logic                     done,
  output logic [ssp_pkg::DIVD_W-1:0] quotient
);
  import ssp_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W);

  logic [DVSR_W-1:0] rem_r, rem_nxt;
  logic [DVSR_W-1:0] dvsr_r;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DVSR_W:0]   shifted;
  logic [DVSR_W:0]   diff;
  logic              ge;

  assign shifted = {rem_r, quo_r[DIVD_W-1]};
  assign diff    = shifted - {1'b0, dvsr_r};
  assign ge      = shifted >= {1'b0, dvsr_r};

  always_comb begin
    rem_nxt = ge ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
    quo_nxt = {quo_r[DIVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/core/ssp_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssp_ctrl
// sequencer for requests, divider recompute and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  ssp_pkg::status_t st,
  output ssp_pkg::cmd_t    cmd
);
  import ssp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = DSEL_RPM;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // pending register write recomputes the divider before any request
        if (st.recalc_pending) begin
          cmd.clr_pending = 1'b1;
          cmd.div_start   = 1'b1;
          cmd.div_sel     = DSEL_RPM;
          state_nxt       = ST_RC_RPM;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.capture_item = 1'b1;
            state_nxt        = ST_EXEC;
          end
        end
      end
      ST_RC_RPM: begin
        if (st.div_done) begin
          cmd.cap_q_hi  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_MDIV;
          state_nxt     = ST_RC_DIV;
        end
      end
      ST_RC_DIV: begin
        if (st.div_done) begin
          cmd.cap_q_lo = 1'b1;
          state_nxt    = ST_RC_MUL;
        end
      end
      ST_RC_MUL: begin
        cmd.load_divider = 1'b1;
        state_nxt        = ST_IDLE;
      end
      ST_EXEC: begin
        unique case (st.op)
          OP_TICK: begin
            cmd.do_tick = 1'b1;
            state_nxt   = ST_RESULT;
          end
          OP_STEPS: begin
            cmd.do_move = 1'b1;
            state_nxt   = ST_RESULT;
          end
          OP_ANGLE: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_ANGQ;
            state_nxt     = ST_ANG_Q;
          end
          OP_STOP: begin
            cmd.do_stop = 1'b1;
            state_nxt   = ST_RESULT;
          end
          default: state_nxt = ST_RESULT;
        endcase
      end
      ST_ANG_Q: begin
        if (st.div_done) begin
          cmd.cap_q_lo  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_ANGT;
          state_nxt     = ST_ANG_T;
        end
      end
      ST_ANG_T: begin
        if (st.div_done) begin
          cmd.do_move       = 1'b1;
          cmd.move_from_div = 1'b1;
          state_nxt         = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/ssp_dp.sv -----
// ----------------------------------------------------------------------------
// ssp_dp
// channel state, configuration registers, divider and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_dp #(
  parameter int MAX_RPM      = ssp_pkg::MAX_RPM_DEF,
  parameter int MAX_DIVISION = ssp_pkg::MAX_DIVISION_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  ssp_pkg::cmd_t     cmd,
  output ssp_pkg::status_t  st,
  // request payload
  input  wire [1:0]         operation,
  input  wire [1:0]         direction,
  input  wire [31:0]        amount,
  // result register
  output logic              out_valid,
  input  wire               out_ready,
  output logic              step_line,
  output logic              direction_line,
  output logic              enable_line,
  output logic              running,
  output logic [31:0]       steps_done,
  // register port
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire [2:0]         paddr,
  input  wire [31:0]        pwdata,
  output logic [31:0]       prdata
);
  import ssp_pkg::*;

  localparam int PROD_W = SPD_W + DQ_W;

  // item registers
  logic [1:0]  op_r;
  logic [1:0]  dir_r;
  logic [31:0] amount_r;

  // configuration
  logic [SPD_W-1:0] speed_r;
  logic [DIV_W-1:0] division_r;
  logic             pending_r;
  logic             cfg_wr;
  logic [SPD_W-1:0] spd_in;
  logic [SPD_W-1:0] spd_wr;
  logic [DIV_W-1:0] div_wr;

  // channel state
  logic        active_r, active_nxt;
  logic [31:0] tick_count_r, tick_count_nxt;
  logic [31:0] tick_divider_r, tick_divider_nxt;
  logic [31:0] toggle_count_r, toggle_count_nxt;
  logic [31:0] step_target_r, step_target_nxt;
  logic        step_level_r, step_level_nxt;
  logic        dir_level_r, dir_level_nxt;
  logic [31:0] tick_inc;
  logic [31:0] toggle_inc;

  // divider recompute
  logic [SPD_W-1:0]  q_hi_r;
  logic [DQ_W-1:0]   q_lo_r;
  logic [PROD_W-1:0] prod;

  // divider unit
  logic [DIVD_W-1:0] div_dividend;
  logic [DVSR_W-1:0] div_divisor;
  logic              div_done;
  logic [DIVD_W-1:0] div_quo;

  logic out_valid_r;

  assign cfg_wr = psel & penable & pwrite;
  assign spd_in = {{(SPD_W-10){1'b0}}, pwdata[9:0]};

  always_comb begin
    spd_wr = spd_in;
    if (spd_in == '0) begin
      spd_wr = SPD_W'(1);
    end else if (spd_in > SPD_W'(MAX_RPM)) begin
      spd_wr = SPD_W'(MAX_RPM);
    end
    div_wr = (pwdata[DIV_W-1:0] == '0) ? DIV_W'(1) : pwdata[DIV_W-1:0];
  end

  always_comb begin
    prdata = (paddr[2] == REG_DIVISION) ? {{(32-DIV_W){1'b0}}, division_r}
                                        : {{(32-SPD_W){1'b0}}, speed_r};
  end

  always_comb begin
    unique case (cmd.div_sel)
      DSEL_RPM: begin
        div_dividend = DIVD_W'(MAX_RPM);
        div_divisor  = speed_r;
      end
      DSEL_MDIV: begin
        div_dividend = DIVD_W'(MAX_DIVISION);
        div_divisor  = DVSR_W'(division_r);
      end
      DSEL_ANGQ: begin
        div_dividend = DIVD_W'(ANGLE_QUARTER);
        div_divisor  = DVSR_W'(division_r);
      end
      DSEL_ANGT: begin
        // quarter-angle quotient is still held by the divider at this start
        div_dividend = amount_r;
        div_divisor  = DVSR_W'(div_quo[DQ_W-1:0]);
      end
      default: begin
        div_dividend = amount_r;
        div_divisor  = DVSR_W'(q_lo_r);
      end
    endcase
  end

  ssp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign prod       = q_hi_r * q_lo_r;
  assign tick_inc   = tick_count_r + 32'd1;
  assign toggle_inc = toggle_count_r + 32'd1;

  always_comb begin
    active_nxt       = active_r;
    tick_count_nxt   = tick_count_r;
    tick_divider_nxt = tick_divider_r;
    toggle_count_nxt = toggle_count_r;
    step_target_nxt  = step_target_r;
    step_level_nxt   = step_level_r;
    dir_level_nxt    = dir_level_r;

    if (cmd.do_tick && active_r) begin
      if (tick_inc >= tick_divider_r) begin
        tick_count_nxt = '0;
        step_level_nxt = ~step_level_r;
        // a zero target runs without counting
        if (step_target_r != '0) begin
          toggle_count_nxt = toggle_inc;
          if (toggle_inc >= step_target_r) begin
            active_nxt     = 1'b0;
            step_level_nxt = 1'b0;
            dir_level_nxt  = 1'b0;
          end
        end
      end else begin
        tick_count_nxt = tick_inc;
      end
    end

    if (cmd.do_move) begin
      step_target_nxt  = cmd.move_from_div ? div_quo : amount_r;
      toggle_count_nxt = '0;
      active_nxt       = 1'b1;
      if (dir_r == DIR_LOW) begin
        dir_level_nxt = 1'b0;
      end else if (dir_r != DIR_KEEP) begin
        dir_level_nxt = 1'b1;
      end
    end

    if (cmd.do_stop) begin
      active_nxt     = 1'b0;
      step_level_nxt = 1'b0;
      dir_level_nxt  = 1'b0;
    end

    if (cmd.load_divider) begin
      tick_divider_nxt = {{(32-PROD_W){1'b0}}, prod};
    end

    if (cfg_wr) begin
      tick_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r       <= 1'b0;
      tick_count_r   <= '0;
      tick_divider_r <= 32'(MAX_DIVISION);
      toggle_count_r <= '0;
      step_target_r  <= '0;
      step_level_r   <= 1'b0;
      dir_level_r    <= 1'b0;
      speed_r        <= SPD_W'(MAX_RPM);
      division_r     <= DIV_W'(1);
      pending_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      active_r       <= active_nxt;
      tick_count_r   <= tick_count_nxt;
      tick_divider_r <= tick_divider_nxt;
      toggle_count_r <= toggle_count_nxt;
      step_target_r  <= step_target_nxt;
      step_level_r   <= step_level_nxt;
      dir_level_r    <= dir_level_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_DIVISION) begin
          division_r <= div_wr;
        end else begin
          speed_r <= spd_wr;
        end
      end
      // a write landing during a recompute starts another one
      if (cfg_wr) begin
        pending_r <= 1'b1;
      end else if (cmd.clr_pending) begin
        pending_r <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_item) begin
      op_r     <= operation;
      dir_r    <= direction;
      amount_r <= amount;
    end
    if (cmd.cap_q_hi) begin
      q_hi_r <= div_quo[SPD_W-1:0];
    end
    if (cmd.cap_q_lo) begin
      q_lo_r <= div_quo[DQ_W-1:0];
    end
    if (cmd.load_out) begin
      step_line      <= step_level_r;
      direction_line <= dir_level_r;
      enable_line    <= active_r;
      running        <= active_r;
      steps_done     <= toggle_count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign st.recalc_pending = pending_r;
  assign st.div_done       = div_done;
  assign st.op             = op_t'(op_r);
  assign st.out_free       = ~out_valid_r | out_ready;

endmodule

`default_nettype wire

// ----- rtl/core/stepper_step_pulse_generator.sv -----
// tick, move by steps and stop requests pass the execute state, then wait in the result state
// until the result register is free; a move by angle first runs two passes of the 32-bit divider
// a new request is taken only in the idle state, once the previous result has been loaded
// a register write recomputes the tick divider, no request taken meanwhile
// reset: synchronous active-low rst_n, speed at maximum rpm, division 1, channel stopped
// ----------------------------------------------------------------------------
// stepper_step_pulse_generator
// one stepper channel producing step, direction and enable line levels
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_step_pulse_generator #(
  parameter int MAX_RPM      = ssp_pkg::MAX_RPM_DEF,
  parameter int MAX_DIVISION = ssp_pkg::MAX_DIVISION_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  ssp_in_if.sink       in_ch,
  ssp_out_if.source    out_ch,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [2:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ssp_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    in_ready;

  ssp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ssp_dp #(
    .MAX_RPM      (MAX_RPM),
    .MAX_DIVISION (MAX_DIVISION)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .operation      (in_ch.operation),
    .direction      (in_ch.direction),
    .amount         (in_ch.amount),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .step_line      (out_ch.step_line),
    .direction_line (out_ch.direction_line),
    .enable_line    (out_ch.enable_line),
    .running        (out_ch.running),
    .steps_done     (out_ch.steps_done),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata)
  );

  assign in_ch.ready = in_ready;
  assign pready      = 1'b1;

endmodule

`default_nettype wire

// ----- rtl/core/ssp_chk.sv -----
// ----------------------------------------------------------------------------
// ssp_chk
// port-level checks on the step pulse generator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "stepper_step_pulse_generator_defines.svh"

module ssp_chk (
  input wire clk,
  input wire rst_n,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire step_line,
  input wire direction_line,
  input wire enable_line,
  input wire running,
  input wire psel,
  input wire penable,
  input wire pwrite
);

  `SSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  `SSP_ASSERT_SAME(a_enable_run, out_valid, enable_line == running, "enable differs from running")

  // a stopped channel always shows both lines low
  `SSP_ASSERT_SAME(a_idle_lines, out_valid && !running, !step_line && !direction_line, "lines high while stopped")

  // register write forces a divider recompute before the next request
  `SSP_ASSERT_NEXT(a_cfg_block, psel && penable && pwrite, !in_ready, "request taken during recompute")

endmodule

bind stepper_step_pulse_generator ssp_chk u_ssp_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .step_line      (out_ch.step_line),
  .direction_line (out_ch.direction_line),
  .enable_line    (out_ch.enable_line),
  .running        (out_ch.running),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite)
);

`default_nettype wire

// ----- verif/stepper_step_pulse_generator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_step_pulse_generator_tb
// drives tick, move and stop requests through several speed and division
// settings, keeps its own model of the channel lines and toggle count, and
// checks every result in order against it under random stalls on both sides
// ----------------------------------------------------------------------------

module stepper_step_pulse_generator_tb;
  import ssp_pkg::*;

  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          DRAIN_CYCLES  = 80;
  localparam logic [2:0]  ADDR_SPEED    = 3'd0;
  localparam logic [2:0]  ADDR_DIVISION = 3'd4;
  localparam logic [1:0]  DIR_HIGH      = 2'd2;
  localparam logic [1:0]  DIR_HIGH_ALT  = 2'd3;

  typedef struct packed {
    op_t         op;
    logic [1:0]  dir;
    logic [31:0] amount;
  } step_req_t;

  typedef struct packed {
    logic        step_line;
    logic        direction_line;
    logic        enable_line;
    logic        running;
    logic [31:0] steps_done;
  } line_state_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ssp_in_if  req_if ();
  ssp_out_if res_if ();

  stepper_step_pulse_generator DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_if),
    .out_ch  (res_if),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready)
  );

  // channel model
  logic        ch_active;
  logic [31:0] tick_acc;
  logic [31:0] tick_period;
  logic [31:0] toggles;
  logic [31:0] target;
  logic        step_lvl;
  logic        dir_lvl;
  logic [15:0] spd_reg;
  logic [5:0]  div_reg;

  step_req_t   pending_reqs[$];
  line_state_t expected_lines[$];
  step_req_t   live_req;
  int          gap_left;
  int          stall_left;
  bit          calm;
  int          errors;
  int          cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] period_of(logic [15:0] spd, logic [5:0] dv);
    return (MAX_RPM_DEF / spd) * (MAX_DIVISION_DEF / dv);
  endfunction

  task automatic apply_request(input step_req_t rq);
    line_state_t e;
    logic [31:0] quarter;
    case (rq.op)
      OP_TICK: begin
        if (ch_active) begin
          tick_acc = tick_acc + 1;
          if (tick_acc >= tick_period) begin
            tick_acc = 0;
            step_lvl = ~step_lvl;
            // endless runs leave the toggle count alone
            if (target != 0) begin
              toggles = toggles + 1;
              if (toggles >= target) begin
                ch_active = 1'b0;
                step_lvl  = 1'b0;
                dir_lvl   = 1'b0;
              end
            end
          end
        end
      end
      OP_STEPS, OP_ANGLE: begin
        quarter   = ANGLE_QUARTER / div_reg;
        target    = (rq.op == OP_STEPS) ? rq.amount : rq.amount / quarter;
        toggles   = 0;
        ch_active = 1'b1;
        if (rq.dir == DIR_LOW) begin
          dir_lvl = 1'b0;
        end else if (rq.dir != DIR_KEEP) begin
          dir_lvl = 1'b1;
        end
      end
      default: begin
        ch_active = 1'b0;
        step_lvl  = 1'b0;
        dir_lvl   = 1'b0;
      end
    endcase
    e.step_line      = step_lvl;
    e.direction_line = dir_lvl;
    e.enable_line    = ch_active;
    e.running        = ch_active;
    e.steps_done     = toggles;
    expected_lines.push_back(e);
  endtask

  // request driver
  always @(posedge clk) begin : req_driver
    step_req_t nxt;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) apply_request(live_req);
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          req_if.valid <= 1'b0;
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          live_req = nxt;
          req_if.valid     <= 1'b1;
          req_if.operation <= nxt.op;
          req_if.direction <= nxt.dir;
          req_if.amount    <= nxt.amount;
          if ($urandom_range(0, 49) == 0) calm = !calm;
          gap_left = calm ? 0 : $urandom_range(0, 13);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic field_check(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin : res_monitor
    line_state_t e;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_lines.size() == 0) begin
          $display("%0t result with no request outstanding: expected none actual %0d",
                   $time, res_if.steps_done);
          errors++;
        end else begin
          e = expected_lines.pop_front();
          field_check("step_line", e.step_line, res_if.step_line);
          field_check("direction_line", e.direction_line, res_if.direction_line);
          field_check("enable_line", e.enable_line, res_if.enable_line);
          field_check("running", e.running, res_if.running);
          field_check("steps_done", e.steps_done, res_if.steps_done);
        end
        stall_left = calm ? 0 : $urandom_range(0, 13);
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic add_request(input op_t op, input logic [1:0] dir, input logic [31:0] amt);
    step_req_t rq;
    rq.op     = op;
    rq.dir    = dir;
    rq.amount = amt;
    pending_reqs.push_back(rq);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req_if.valid || expected_lines.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] v;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_SPEED) begin
      v = data & 32'h3ff;
      if (v == 0) v = 1;
      if (v > MAX_RPM_DEF) v = MAX_RPM_DEF;
      spd_reg = v[15:0];
    end else begin
      v = data & 32'h3f;
      if (v == 0) v = 1;
      div_reg = v[5:0];
    end
    tick_period = period_of(spd_reg, div_reg);
    tick_acc    = 0;
  endtask

  task automatic set_config(input logic [31:0] spd, input logic [31:0] dv);
    wait_idle();
    write_reg(ADDR_SPEED, spd);
    write_reg(ADDR_DIVISION, dv);
  endtask

  // moves each followed by up to 40 ticks, with some stops and noise
  task automatic run_random(input int count);
    int          n;
    int          t;
    int          pick;
    int          nticks;
    op_t         op;
    logic [31:0] q;
    logic [31:0] amt;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 15);
      if (pick < 12) begin
        t = $urandom_range(1, 6);
        if ($urandom_range(0, 9) == 0) t = 0;
        op = ($urandom_range(0, 2) != 0) ? OP_STEPS : OP_ANGLE;
        q = ANGLE_QUARTER / div_reg;
        if (op == OP_STEPS) amt = t;
        else amt = t * q + $urandom_range(0, q - 1);
        if ($urandom_range(0, 19) == 0) amt = $urandom;
        add_request(op, 2'($urandom_range(0, 3)), amt);
        nticks = (tick_period == 0 ? 1 : tick_period) * (t == 0 ? 3 : t)
                 + $urandom_range(0, 3);
        if (nticks > 40) nticks = $urandom_range(20, 40);
        for (int k = 0; k < nticks; k++) begin
          if ($urandom_range(0, 29) == 0)
            add_request(OP_STOP, 2'($urandom_range(0, 3)), $urandom);
          else
            add_request(OP_TICK, 2'($urandom_range(0, 3)), $urandom);
        end
        n += nticks + 1;
      end else if (pick < 14) begin
        add_request(pick == 12 ? OP_STOP : OP_TICK, 2'($urandom_range(0, 3)), $urandom);
        n++;
      end else begin
        add_request(op_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom);
        n++;
      end
    end
  endtask

  initial begin
    logic [31:0] spd_list[8] = '{1023, 0, 300, 150, 1, 599, 200, 0};
    logic [31:0] div_list[8] = '{63, 0, 16, 8, 33, 31, 5, 0};
    int          len_list[8] = '{230, 80, 240, 240, 200, 240, 200, 160};

    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.operation = OP_TICK;
    req_if.direction = DIR_KEEP;
    req_if.amount    = '0;
    res_if.ready = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    cycles       = 0;
    errors       = 0;
    calm         = 1'b0;
    gap_left     = 0;
    stall_left   = 0;

    ch_active   = 1'b0;
    tick_acc    = 0;
    toggles     = 0;
    target      = 0;
    step_lvl    = 1'b0;
    dir_lvl     = 1'b0;
    spd_reg     = MAX_RPM_DEF;
    div_reg     = 6'd1;
    tick_period = period_of(spd_reg, div_reg);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: idle channel, endless run, restarts while running
    add_request(OP_TICK, DIR_HIGH, 32'hffff_ffff);
    add_request(OP_STOP, DIR_HIGH_ALT, 32'hffff_ffff);
    add_request(OP_STEPS, DIR_HIGH_ALT, 32'd0);
    add_request(OP_TICK, DIR_KEEP, 32'd0);
    add_request(OP_TICK, DIR_LOW, 32'd1);
    add_request(OP_ANGLE, DIR_LOW, 32'hffff_ffff);
    add_request(OP_TICK, DIR_KEEP, 32'd0);
    add_request(OP_STEPS, DIR_KEEP, 32'hffff_ffff);
    add_request(OP_STOP, DIR_KEEP, 32'd0);

    // divider of one: targets reached within a few ticks
    set_config(MAX_RPM_DEF, MAX_DIVISION_DEF);
    add_request(OP_STEPS, DIR_HIGH, 32'd2);
    repeat (3) add_request(OP_TICK, DIR_KEEP, 32'd0);
    add_request(OP_ANGLE, DIR_LOW, 32'd5);
    repeat (3) add_request(OP_TICK, DIR_HIGH, 32'd7);
    add_request(OP_STEPS, DIR_KEEP, 32'd1);
    add_request(OP_TICK, DIR_KEEP, 32'd0);
    add_request(OP_STEPS, DIR_HIGH, 32'd0);
    add_request(OP_TICK, DIR_KEEP, 32'd0);
    add_request(OP_STOP, DIR_LOW, 32'd3);
    run_random(120);
    // hold the sender back until the channel has drained
    wait_idle();
    run_random(110);

    foreach (spd_list[i]) begin
      if (i == 7) set_config($urandom_range(0, 1023), $urandom_range(0, 63));
      else set_config(spd_list[i], div_list[i]);
      run_random(len_list[i]);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_lines.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/ssp_pkg.sv
rtl/core/ssp_if.sv
rtl/core/ssp_div.sv
rtl/core/ssp_ctrl.sv
rtl/core/ssp_dp.sv
rtl/core/stepper_step_pulse_generator.sv
rtl/core/ssp_chk.sv
verif/stepper_step_pulse_generator_tb.sv
